/* hdl/sewr_pkg.sv */
// Package for the stack engine with roll: widths, opcodes, status codes
// and the sequencer states. No dependencies.
package sewr_pkg;

    localparam int STACK_DEPTH_DEF = 256;
    localparam int WORD_W          = 32;
    localparam int OCC_W           = 9;
    localparam int S_TDATA_W       = 96;
    localparam int M_TDATA_W       = 48;
    localparam int DIV_STEPS       = 32;
    localparam int ITER_W          = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_PEEK = 2'd2,
        OP_ROLL = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_TOO_DEEP = 3'd2,
        ST_NOT_POS  = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_DIV,
        S_FIX,
        S_CYC_START,
        S_CYC_SAVE,
        S_CYC_MOVE,
        S_CYC_CLOSE
    } state_t;

endpackage

/* hdl/stack_engine_with_roll_core.sv */
// Stack engine with roll: bounded LIFO of 32-bit words with push, pop, peek
// and roll. Depends on sewr_pkg.
//
// Usage: one operation per transfer on the s_axis channel, one result per
// operation on the m_axis channel. s_axis_tuser carries the opcode, s_axis_tdata
// the push value, roll depth and roll count. m_axis_tuser carries the status,
// m_axis_tdata the read word and the occupancy after the operation.
// A roll that rotates runs a 32-step remainder unit (count mod depth, one bit
// per cycle), then moves the entries through the one-read, one-write stack
// memory one per cycle along each rotation cycle; a roll whose shift reduces
// to zero ends after the remainder unit. The input is not ready until the
// operation ends and its result has left the result register.
// A result waits in the output register while the receiver stalls; the next
// operation is accepted and runs, and its result is held until the output
// register frees. Reset empties the stack and drops any pending result; the
// memory contents are left as they are.
module stack_engine_with_roll_core #(
    parameter int STACK_DEPTH = sewr_pkg::STACK_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // push_value [31:0], roll_depth [63:32], roll_count [95:64]
    input  logic [sewr_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // opcode [1:0]
    input  logic [1:0]                     s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // read_data [31:0], occupancy [40:32], zero [47:41]
    output logic [sewr_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // status [2:0]
    output logic [2:0]                     m_axis_tuser
);
    import sewr_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    logic [WORD_W-1:0] mem [STACK_DEPTH];
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [WORD_W-1:0] rd_data_reg;

    state_t            state_reg,      state_next;
    logic [CW-1:0]     count_reg,      count_next;
    logic [WORD_W-1:0] res_data_reg,   res_data_next;
    status_t           res_status_reg, res_status_next;
    logic              res_valid_reg,  res_valid_next;
    logic              out_valid_reg,  out_valid_next;
    logic [WORD_W-1:0] out_data_reg,   out_data_next;
    status_t           out_status_reg, out_status_next;
    logic [OCC_W-1:0]  out_occ_reg,    out_occ_next;
    logic [CW-1:0]     depth_reg,      depth_next;
    logic              neg_reg,        neg_next;
    logic [WORD_W-1:0] dvd_reg,        dvd_next;
    logic [CW-1:0]     rem_reg,        rem_next;
    logic [ITER_W-1:0] iter_reg,       iter_next;
    logic [AW-1:0]     rot_reg,        rot_next;
    logic [AW-1:0]     base_reg,       base_next;
    logic [AW-1:0]     start_reg,      start_next;
    logic [AW-1:0]     dst_reg,        dst_next;
    logic [AW-1:0]     src_reg,        src_next;
    logic [CW-1:0]     moves_reg,      moves_next;
    logic [WORD_W-1:0] tmp_reg,        tmp_next;

    opcode_t            in_opcode;
    logic [WORD_W-1:0]  in_value;
    logic signed [WORD_W-1:0] in_depth;
    logic signed [WORD_W-1:0] in_count;
    logic               out_free;
    logic [CW:0]        rem_shift;
    logic [AW-1:0]      step_in;
    logic [CW:0]        wrap_sum;
    logic [AW-1:0]      step_out;

    assign in_opcode = opcode_t'(s_axis_tuser);
    assign in_value  = s_axis_tdata[WORD_W-1:0];
    assign in_depth  = s_axis_tdata[2*WORD_W-1:WORD_W];
    assign in_count  = s_axis_tdata[3*WORD_W-1:2*WORD_W];

    assign s_axis_tready = (state_reg == S_IDLE) && !res_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(M_TDATA_W - WORD_W - OCC_W)'(0), out_occ_reg, out_data_reg};
    assign m_axis_tuser  = out_status_reg;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // remainder step, and rotation index unit shared by the save and move states
    assign rem_shift = {rem_reg, dvd_reg[WORD_W-1]};
    assign step_in   = (state_reg == S_CYC_SAVE) ? dst_reg : src_reg;
    assign wrap_sum  = (CW + 1)'(step_in) + (CW + 1)'(depth_reg) - (CW + 1)'(rot_reg);
    assign step_out  = (step_in >= rot_reg) ? AW'(step_in - rot_reg) : AW'(wrap_sum);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        res_data_next   = res_data_reg;
        res_status_next = res_status_reg;
        res_valid_next  = res_valid_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        out_occ_next    = out_occ_reg;
        depth_next      = depth_reg;
        neg_next        = neg_reg;
        dvd_next        = dvd_reg;
        rem_next        = rem_reg;
        iter_next       = iter_reg;
        rot_next        = rot_reg;
        base_next       = base_reg;
        start_next      = start_reg;
        dst_next        = dst_reg;
        src_next        = src_reg;
        moves_next      = moves_reg;
        tmp_next        = tmp_reg;
        mem_we          = 1'b0;
        mem_waddr       = dst_reg + base_reg;
        mem_wdata       = rd_data_reg;
        mem_re          = 1'b0;
        mem_raddr       = step_out + base_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        // move a finished result into the output register
        if (res_valid_reg && out_free)
        begin
            out_valid_next  = 1'b1;
            out_data_next   = res_data_reg;
            out_status_next = res_status_reg;
            out_occ_next    = OCC_W'(count_reg);
            res_valid_next  = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid && s_axis_tready)
                begin
                    res_data_next   = '0;
                    res_status_next = ST_OK;
                    res_valid_next  = 1'b1;
                    unique case (in_opcode)
                        OP_PUSH:
                        begin
                            if (count_reg == CW'(STACK_DEPTH))
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = count_reg[AW-1:0];
                                mem_wdata  = in_value;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_POP, OP_PEEK:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                mem_re         = 1'b1;
                                mem_raddr      = AW'(count_reg - 1'b1);
                                res_valid_next = 1'b0;
                                state_next     = S_READ;
                                if (in_opcode == OP_POP)
                                begin
                                    count_next = count_reg - 1'b1;
                                end
                            end
                        end
                        OP_ROLL:
                        begin
                            if (in_depth[WORD_W-1] || (in_depth == '0))
                            begin
                                res_status_next = ST_NOT_POS;
                            end
                            else if (in_depth > $signed(WORD_W'(count_reg)))
                            begin
                                res_status_next = ST_TOO_DEEP;
                            end
                            else
                            begin
                                res_valid_next = 1'b0;
                                depth_next     = CW'(in_depth);
                                neg_next       = in_count[WORD_W-1];
                                dvd_next       = in_count[WORD_W-1] ? WORD_W'(-in_count)
                                                                    : WORD_W'(in_count);
                                rem_next       = '0;
                                iter_next      = '0;
                                state_next     = S_DIV;
                            end
                        end
                    endcase
                end
            end
            S_READ:
            begin
                res_data_next  = rd_data_reg;
                res_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            S_DIV:
            begin
                if (rem_shift >= (CW + 1)'(depth_reg))
                begin
                    rem_next = CW'(rem_shift - (CW + 1)'(depth_reg));
                end
                else
                begin
                    rem_next = CW'(rem_shift);
                end
                dvd_next  = dvd_reg << 1;
                iter_next = iter_reg + 1'b1;
                if (iter_reg == ITER_W'(DIV_STEPS - 1))
                begin
                    state_next = S_FIX;
                end
            end
            S_FIX:
            begin
                if (rem_reg == '0)
                begin
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    rot_next   = neg_reg ? AW'(depth_reg - rem_reg) : AW'(rem_reg);
                    base_next  = AW'(count_reg - depth_reg);
                    start_next = '0;
                    moves_next = '0;
                    state_next = S_CYC_START;
                end
            end
            S_CYC_START:
            begin
                mem_re     = 1'b1;
                mem_raddr  = start_reg + base_reg;
                dst_next   = start_reg;
                state_next = S_CYC_SAVE;
            end
            S_CYC_SAVE:
            begin
                tmp_next   = rd_data_reg;
                mem_re     = 1'b1;
                src_next   = step_out;
                state_next = S_CYC_MOVE;
            end
            S_CYC_MOVE:
            begin
                mem_we     = 1'b1;
                moves_next = moves_reg + 1'b1;
                dst_next   = src_reg;
                if (step_out == start_reg)
                begin
                    state_next = S_CYC_CLOSE;
                end
                else
                begin
                    mem_re   = 1'b1;
                    src_next = step_out;
                end
            end
            S_CYC_CLOSE:
            begin
                mem_we     = 1'b1;
                mem_wdata  = tmp_reg;
                moves_next = moves_reg + 1'b1;
                if ((moves_reg + 1'b1) == depth_reg)
                begin
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    start_next = start_reg + 1'b1;
                    state_next = S_CYC_START;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_data_reg   <= res_data_next;
        res_status_reg <= res_status_next;
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
        out_occ_reg    <= out_occ_next;
        depth_reg      <= depth_next;
        neg_reg        <= neg_next;
        dvd_reg        <= dvd_next;
        rem_reg        <= rem_next;
        iter_reg       <= iter_next;
        rot_reg        <= rot_next;
        base_reg       <= base_next;
        start_reg      <= start_next;
        dst_reg        <= dst_next;
        src_reg        <= src_next;
        moves_reg      <= moves_next;
        tmp_reg        <= tmp_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

endmodule
